// ===== hw/rtl/snmfs_pkg.sv =====
// Package for the sorted number map: shared types and action codes.
// No dependencies.
package snmfs_pkg;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_FIND   = 2'd2,
      ACT_FREE   = 2'd3
   } action_type;

   localparam int unsigned CSR_GLOBAL_MODE = 0;
   localparam int unsigned CSR_MAX_NUMBER  = 1;

   typedef struct packed {
      action_type  action;
      logic [15:0] number_in;
      logic [7:0]  slot_in;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [7:0]  slot_out;
      logic [15:0] free_number;
      logic        table_full;
   } rsp_type;

endpackage

// ===== hw/rtl/snmfs_if.sv =====
// Valid/ready channel interface carrying one word of a payload type.
// No package dependency; the payload type is a parameter.
interface snmfs_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sorted_number_map_free_search.sv =====
// Sorted number map with free-number search. A find, remove or insert runs a binary search
// of the table, p <= log2(entries) + 1 probes, then gives its response word. Insert then
// shifts each entry at or above the insert point up by one; remove shifts each entry after
// the hit down by one. Find-free repeats a full search per candidate, up to MAX_TRIES times. One item
// is worked at a time, the next the cycle after a response word is accepted; a two-word
// queue sits before it. Reset (synchronous, active high) empties the table and restores
// register defaults.
module sorted_number_map_free_search #(
   parameter int unsigned TABLE_DEPTH = 256,
   parameter int unsigned MAX_TRIES   = 1000
) (
   input  logic        clock,
   input  logic        reset,
   snmfs_if.sink       req,
   snmfs_if.source     rsp,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import snmfs_pkg::*;

   logic        global_mode_ff;
   logic [15:0] max_number_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         global_mode_ff <= 1'b0;
         max_number_ff  <= 16'hFFFF;
      end else if (csr_write) begin
         if (csr_index == 1'(CSR_GLOBAL_MODE)) global_mode_ff <= csr_wdata[0];
         if (csr_index == 1'(CSR_MAX_NUMBER))  max_number_ff  <= csr_wdata;
      end
   end

   logic    q_valid, q_ready;
   req_type q_data;

   snmfs_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
   );

   snmfs_back #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_TRIES(MAX_TRIES)) u_back (
      .clock(clock), .reset(reset),
      .global_mode(global_mode_ff), .max_number(max_number_ff),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
   );
endmodule

// ===== hw/rtl/snmfs_front.sv =====
// Front end: accepts request words and queues them.
// Depends on snmfs_pkg.
module snmfs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  snmfs_pkg::req_type in_data,
   output logic              q_valid,
   input  logic              q_ready,
   output snmfs_pkg::req_type q_data
);
   import snmfs_pkg::*;

   // Two-entry queue between front and back.
   req_type    q_mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != 2'd0);
   assign pop      = q_valid && q_ready;
   assign q_data   = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Payload storage; the free search start parity is fixed later in the back end.
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= in_data;
      end
   end
endmodule

// ===== hw/rtl/snmfs_back.sv =====
// Back end: binary search, shifting insert/remove and free-number search.
// Depends on snmfs_pkg.
module snmfs_back #(
   parameter int unsigned TABLE_DEPTH = 256,
   parameter int unsigned MAX_TRIES   = 1000
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               global_mode,
   input  logic [15:0]        max_number,
   input  logic               q_valid,
   output logic               q_ready,
   input  snmfs_pkg::req_type q_data,
   output logic               out_valid,
   input  logic               out_ready,
   output snmfs_pkg::rsp_type out_data
);
   import snmfs_pkg::*;

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned TW = $clog2(MAX_TRIES + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SRCH, ST_RD, ST_CMP, ST_DECIDE,
      ST_INS_RD, ST_INS_WR, ST_REM_RD, ST_REM_WR, ST_OUT
   } state_type;

   // Table memory: number in the upper 16 bits, slot in the lower 8.
   logic [23:0] mem [TABLE_DEPTH];
   logic [23:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [23:0]   wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   state_type     state_ff;
   logic [CW-1:0] count_ff, lo_ff, hi_ff, mid_ff, pos_ff;
   action_type    act_ff;
   logic [15:0]   num_ff;
   logic [16:0]   cand_ff;
   logic [7:0]    slot_ff;
   logic [TW-1:0] tries_ff;
   rsp_type       rsp_ff;

   logic [16:0] wrap_val;
   logic [16:0] start_adj;
   logic [16:0] cand_next;
   logic [15:0] mid_num;
   assign wrap_val = global_mode ? 17'd2 : 17'd1;
   assign start_adj = {1'b0, q_data.number_in}
                      + {16'd0, (q_data.number_in[0] == global_mode)};
   assign cand_next = cand_ff + 17'd2;
   assign mid_num = rd_data_ff[23:8];

   // Memory port selection.
   always_comb begin
      rd_addr = mid_ff[AW-1:0];
      wr_en   = 1'b0;
      wr_addr = pos_ff[AW-1:0];
      wr_data = rd_data_ff;
      unique case (state_ff)
         ST_INS_RD: rd_addr = AW'(pos_ff - 1'b1);
         ST_REM_RD: rd_addr = AW'(pos_ff + 1'b1);
         ST_INS_WR, ST_REM_WR: begin
            wr_en = 1'b1;
            if (state_ff == ST_INS_WR && pos_ff == lo_ff) begin
               wr_data = {num_ff, slot_ff};
            end else begin
               wr_data = rd_data_ff;
            end
         end
         default: ;
      endcase
   end

   assign q_ready   = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_OUT);
   assign out_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: if (q_valid) begin
               act_ff   <= q_data.action;
               num_ff   <= q_data.number_in;
               slot_ff  <= q_data.slot_in;
               tries_ff <= '0;
               rsp_ff   <= '0;
               cand_ff  <= (start_adj > {1'b0, max_number}) ? wrap_val : start_adj;
               state_ff <= ST_SRCH;
            end
            // Start a binary search for num_ff, or the candidate.
            ST_SRCH: begin
               lo_ff    <= '0;
               hi_ff    <= count_ff;
               if (act_ff == ACT_FREE) num_ff <= cand_ff[15:0];
               state_ff <= ST_RD;
            end
            ST_RD: begin
               if (lo_ff < hi_ff) begin
                  mid_ff   <= lo_ff + ((hi_ff - lo_ff) >> 1);
                  state_ff <= ST_CMP;
               end else begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_CMP: state_ff <= ST_DECIDE;
            default: ;
         endcase
         // Compare a read word; ST_CMP only waits for registered read data.
         if (state_ff == ST_DECIDE) begin
            if (lo_ff < hi_ff && mid_num != num_ff) begin
               if (mid_num > num_ff) hi_ff <= mid_ff;
               else                  lo_ff <= mid_ff + 1'b1;
               state_ff <= ST_RD;
            end else begin
               if (lo_ff < hi_ff) lo_ff <= mid_ff;
               priority case (act_ff)
                  ACT_FREE: begin
                     if (lo_ff >= hi_ff) begin
                        rsp_ff.free_number <= num_ff;
                        state_ff <= ST_OUT;
                     end else if (tries_ff == TW'(MAX_TRIES - 1)) begin
                        state_ff <= ST_OUT;
                     end else begin
                        tries_ff <= tries_ff + 1'b1;
                        cand_ff  <= (cand_next > {1'b0, max_number}) ? wrap_val : cand_next;
                        state_ff <= ST_SRCH;
                     end
                  end
                  default: begin
                     if (lo_ff < hi_ff) begin
                        rsp_ff.hit      <= 1'b1;
                        rsp_ff.slot_out <= rd_data_ff[7:0];
                     end
                     if (act_ff == ACT_INSERT && lo_ff >= hi_ff) begin
                        if (count_ff == CW'(TABLE_DEPTH)) begin
                           rsp_ff.table_full <= 1'b1;
                           state_ff <= ST_OUT;
                        end else begin
                           pos_ff   <= count_ff;
                           state_ff <= ST_INS_RD;
                        end
                     end else if (act_ff == ACT_REMOVE && lo_ff < hi_ff) begin
                        pos_ff   <= mid_ff;
                        state_ff <= ST_REM_RD;
                     end else begin
                        state_ff <= ST_OUT;
                     end
                  end
               endcase
            end
         end
         // Shift up for insert: pos walks down from count to the insert point.
         if (state_ff == ST_INS_RD) state_ff <= ST_INS_WR;
         if (state_ff == ST_INS_WR) begin
            if (pos_ff == lo_ff) begin
               count_ff <= count_ff + 1'b1;
               state_ff <= ST_OUT;
            end else begin
               pos_ff   <= pos_ff - 1'b1;
               state_ff <= ST_INS_RD;
            end
         end
         // Shift down for remove.
         if (state_ff == ST_REM_RD) begin
            if (pos_ff + 1'b1 >= count_ff) begin
               count_ff <= count_ff - 1'b1;
               state_ff <= ST_OUT;
            end else begin
               state_ff <= ST_REM_WR;
            end
         end
         if (state_ff == ST_REM_WR) begin
            pos_ff   <= pos_ff + 1'b1;
            state_ff <= ST_REM_RD;
         end
         if (state_ff == ST_OUT && out_ready) state_ff <= ST_IDLE;
      end
   end
endmodule
